// File: rtl/core/dynamic_priority_scheduler_defines.svh
// ----------------------------------------------------------------------------
// dynamic priority scheduler assertion macros
// shared property forms for the scheduler's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH

// condition implies consequence in the same cycle
`define DPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// shared widths, codes and types of the dynamic priority scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

   localparam int PRIO_W          = 8;
   localparam int TIME_W          = 8;
   localparam int SLOT_W          = 3;
   localparam int TOTAL_W         = 11;
   localparam int DEF_NUM_ENTRIES = 8;

   // request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // lowest priority, decrement saturates here
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

   // one table entry as stored in the memory
   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remain;
   } entry_type;

   // running winner of a selection pass
   typedef struct packed {
      logic                     found;
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remain;
   } best_type;

endpackage

`default_nettype wire

// File: rtl/core/dps_req_if.sv
// ----------------------------------------------------------------------------
// dps_req_if
// request channel of the scheduler: valid, ready and one request
// ----------------------------------------------------------------------------
`default_nettype none

interface dps_req_if;
   import dps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [SLOT_W-1:0]        entry_index;
   logic signed [PRIO_W-1:0] start_priority;
   logic [TIME_W-1:0]        start_time;

   modport source (
      output valid, operation, entry_index, start_priority, start_time,
      input  ready
   );

   modport sink (
      input  valid, operation, entry_index, start_priority, start_time,
      output ready
   );

endinterface

`default_nettype wire

// File: rtl/core/dps_rsp_if.sv
// ----------------------------------------------------------------------------
// dps_rsp_if
// response channel of the scheduler: valid, ready and one tick result
// ----------------------------------------------------------------------------
`default_nettype none

interface dps_rsp_if;
   import dps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SLOT_W-1:0]        chosen_index;
   logic                     ran;
   logic signed [PRIO_W-1:0] new_priority;
   logic [TIME_W-1:0]        time_left;
   logic                     finished;
   logic                     all_done;

   modport source (
      output valid, chosen_index, ran, new_priority, time_left, finished, all_done,
      input  ready
   );

   modport sink (
      input  valid, chosen_index, ran, new_priority, time_left, finished, all_done,
      output ready
   );

endinterface

`default_nettype wire

// File: rtl/core/dynamic_priority_scheduler.sv
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler
// priority scheduler with aging over a memory-held table of process entries
// ----------------------------------------------------------------------------
// The block holds NUM_ENTRIES entries, each a signed priority and a remaining
// run time, in a single-port-read memory with a registered read port. A load
// request writes one entry and produces no response; a slot beyond the table
// is ignored, any other holds off the next request in the load state, since
// the old run time is read back to keep the running total of remaining work.
// A tick request streams every entry out of the memory, one per cycle, through
// a single comparator that keeps the ready entry with the highest priority
// (lowest index on a tie); the winner then loses one priority step (saturating
// at the minimum) and one time unit and is written back. A tick passes
// through the scan and finish states, paced by the one read port. The
// response is held in an output register, so a new request may be accepted
// while it waits; a tick waits only at its final step for the previous
// response to be taken. Memory contents need no clearing pass after reset:
// per-entry valid bits make unwritten entries read as finished with zero
// priority.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dynamic_priority_scheduler_defines.svh"

module dynamic_priority_scheduler #(
   parameter int NUM_ENTRIES = dps_pkg::DEF_NUM_ENTRIES
) (
   input wire logic clock,
   input wire logic reset,
   dps_req_if.sink  req_ch,
   dps_rsp_if.source rsp_ch
);
   import dps_pkg::*;

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   // controller states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;        // address of the read in flight
   entry_type                load_ff, load_in;      // pending load payload
   logic [TOTAL_W-1:0]       total_ff, total_in;    // running sum of run times

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                     rsp_ran_ff, rsp_ran_in;
   logic signed [PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [TIME_W-1:0]        rsp_time_ff, rsp_time_in;
   logic                     rsp_fin_ff, rsp_fin_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     req_fire;
   logic                     slot_ok;
   logic                     out_free;
   logic                     finish_fire;

   logic [IDX_W-1:0]         rd_addr;
   entry_type                rd_data;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   entry_type                wr_data;

   logic                     sel_clear;
   logic                     sel_enable;
   best_type                 best;
   logic [IDX_W-1:0]         best_idx;

   entry_type                aged;
   logic [TOTAL_W-1:0]       total_dec;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_ok      = (32'(req_ch.entry_index) < NUM_ENTRIES);

   // output register is free once empty or being drained this cycle
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign finish_fire = (state_ff == ST_FINISH) && out_free;

   // aged winner: one priority step down (saturating) and one time unit less
   assign aged.prio   = (best.prio == PRIO_MIN) ? PRIO_MIN : best.prio - 1'b1;
   assign aged.remain = best.remain - 1'b1;
   assign total_dec   = total_ff - 1'b1;

   dps_mem #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   dps_sel #(
      .IDX_W (IDX_W)
   ) u_sel (
      .clock     (clock),
      .reset     (reset),
      .clear     (sel_clear),
      .enable    (sel_enable),
      .entry_idx (idx_ff),
      .entry     (rd_data),
      .best      (best),
      .best_idx  (best_idx)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      load_in      = load_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ran_in   = rsp_ran_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_done_in  = rsp_done_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = load_ff;
      sel_clear    = 1'b0;
      sel_enable   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               load_in.prio   = req_ch.start_priority;
               load_in.remain = req_ch.start_time;
               if (req_ch.operation == OP_TICK) begin
                  // start the pass at entry zero
                  rd_addr   = '0;
                  idx_in    = '0;
                  sel_clear = 1'b1;
                  state_in  = ST_SCAN;
               end else if (slot_ok) begin
                  // fetch the old entry to correct the total
                  rd_addr  = IDX_W'(req_ch.entry_index);
                  idx_in   = IDX_W'(req_ch.entry_index);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            total_in = total_ff - TOTAL_W'(rd_data.remain) + TOTAL_W'(load_ff.remain);
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = load_ff;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // data of entry idx_ff is on the read port now
            sel_enable = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (best.found) begin
                  wr_en       = 1'b1;
                  wr_addr     = best_idx;
                  wr_data     = aged;
                  total_in    = total_dec;
                  rsp_idx_in  = SLOT_W'(best_idx);
                  rsp_ran_in  = 1'b1;
                  rsp_prio_in = aged.prio;
                  rsp_time_in = aged.remain;
                  rsp_fin_in  = (aged.remain == '0);
                  rsp_done_in = (total_dec == '0);
               end else begin
                  // nothing ready: empty result, all work done
                  rsp_idx_in  = '0;
                  rsp_ran_in  = 1'b0;
                  rsp_prio_in = '0;
                  rsp_time_in = '0;
                  rsp_fin_in  = 1'b0;
                  rsp_done_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      load_ff     <= load_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_ran_ff  <= rsp_ran_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_time_ff <= rsp_time_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.chosen_index = rsp_idx_ff;
   assign rsp_ch.ran          = rsp_ran_ff;
   assign rsp_ch.new_priority = rsp_prio_ff;
   assign rsp_ch.time_left    = rsp_time_ff;
   assign rsp_ch.finished     = rsp_fin_ff;
   assign rsp_ch.all_done     = rsp_done_ff;

   // a new response only appears as the result of a finished tick
   `DPS_ASSERT_SAME(a_rsp_from_tick, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "response without a completed tick")

   // the table is never written while a selection pass is streaming it
   `DPS_ASSERT_SAME(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN, !wr_en, "table written during scan")

   // a tick that ran consumes exactly one unit of total work
   `DPS_ASSERT_NEXT(a_total_dec, clock, reset, finish_fire && best.found, total_ff == $past(total_dec), "running total not decremented")

endmodule

`default_nettype wire

// File: rtl/core/dps_mem.sv
// ----------------------------------------------------------------------------
// dps_mem
// entry table: one write port, one registered read port, per-entry valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module dps_mem #(
   parameter int NUM_ENTRIES = 8,
   parameter int IDX_W       = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output dps_pkg::entry_type      rd_data,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  dps_pkg::entry_type      wr_data
);
   import dps_pkg::*;

   entry_type              mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [NUM_ENTRIES-1:0] valid_in;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // never-written entries read as the reset value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/core/dps_sel.sv
// ----------------------------------------------------------------------------
// dps_sel
// running maximum over streamed entries, ties kept at the lower index
// ----------------------------------------------------------------------------
`default_nettype none

module dps_sel #(
   parameter int IDX_W = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             enable,
   input  wire logic [IDX_W-1:0] entry_idx,
   input  dps_pkg::entry_type    entry,
   output dps_pkg::best_type     best,
   output logic [IDX_W-1:0]      best_idx
);
   import dps_pkg::*;

   best_type         best_ff;
   best_type         best_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             take;

   // finished entries (zero time) do not compete
   assign take = enable && (entry.remain != '0) &&
                 (!best_ff.found || (entry.prio > best_ff.prio));

   always_comb begin
      best_in = best_ff;
      idx_in  = idx_ff;
      if (clear) begin
         best_in.found = 1'b0;
      end else if (take) begin
         best_in.found  = 1'b1;
         best_in.prio   = entry.prio;
         best_in.remain = entry.remain;
         idx_in         = entry_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.found <= 1'b0;
      end else begin
         best_ff.found <= best_in.found;
      end
      best_ff.prio   <= best_in.prio;
      best_ff.remain <= best_in.remain;
      idx_ff         <= idx_in;
   end

   assign best     = best_ff;
   assign best_idx = idx_ff;

endmodule

`default_nettype wire

// File: verif/dps_sched_checker.sv
// ----------------------------------------------------------------------------
// dps_sched_checker
// watches the request and response channels of the dynamic priority
// scheduler, keeps its own copy of the entry table, predicts every tick
// response and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`default_nettype none

module dps_sched_checker #(
   parameter int NUM_ENTRIES = dps_pkg::DEF_NUM_ENTRIES
) (
   input  wire logic clock,
   input  wire logic reset,
   dps_req_if        req_mon,
   dps_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending
);
   import dps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_W-1:0]        chosen_index;
      logic                     ran;
      logic signed [PRIO_W-1:0] new_priority;
      logic [TIME_W-1:0]        time_left;
      logic                     finished;
      logic                     all_done;
   } tick_result_type;

   logic signed [PRIO_W-1:0] model_prio [NUM_ENTRIES];
   logic [TIME_W-1:0]        model_time [NUM_ENTRIES];
   logic [TOTAL_W-1:0]       work_left;
   tick_result_type          expected_ticks [$];

   function automatic void load_entry(input logic [SLOT_W-1:0] slot,
                                      input logic signed [PRIO_W-1:0] prio,
                                      input logic [TIME_W-1:0] remain);
      if (int'(slot) < NUM_ENTRIES) begin
         work_left        = work_left - model_time[slot] + remain;
         model_prio[slot] = prio;
         model_time[slot] = remain;
      end
   endfunction

   // full selection over ready entries, ties to the lowest slot
   function automatic tick_result_type schedule_tick();
      tick_result_type          res;
      logic                     found;
      int                       best;
      logic signed [PRIO_W-1:0] best_prio;
      res       = '0;
      found     = 1'b0;
      best      = 0;
      best_prio = '0;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         if (model_time[k] != '0 && (!found || model_prio[k] > best_prio)) begin
            found     = 1'b1;
            best      = k;
            best_prio = model_prio[k];
         end
      end
      if (!found) begin
         res.all_done = 1'b1;
         return res;
      end
      if (best_prio != PRIO_MIN) best_prio = best_prio - PRIO_W'(1);
      model_prio[best] = best_prio;
      model_time[best] = model_time[best] - 1'b1;
      work_left        = work_left - 1'b1;
      res.chosen_index = SLOT_W'(best);
      res.ran          = 1'b1;
      res.new_priority = best_prio;
      res.time_left    = model_time[best];
      res.finished     = (model_time[best] == '0);
      res.all_done     = (work_left == '0);
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            model_prio[k] = '0;
            model_time[k] = '0;
         end
         work_left = '0;
         fail_count = 0;
         expected_ticks.delete();
      end else begin
         // responses first, so a stray one is never matched to a tick of this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ticks.size() == 0) begin
               $error("response with no tick outstanding");
               fail_count++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("chosen_index", want.chosen_index, rsp_mon.chosen_index);
               check_field("ran", want.ran, rsp_mon.ran);
               check_field("new_priority", want.new_priority, rsp_mon.new_priority);
               check_field("time_left", want.time_left, rsp_mon.time_left);
               check_field("finished", want.finished, rsp_mon.finished);
               check_field("all_done", want.all_done, rsp_mon.all_done);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == OP_TICK)
               expected_ticks = {expected_ticks, schedule_tick()};
            else
               load_entry(req_mon.entry_index, req_mon.start_priority, req_mon.start_time);
         end
      end
      pending <= expected_ticks.size();
   end

endmodule

`default_nettype wire

// File: verif/tb_dynamic_priority_scheduler.sv
// ----------------------------------------------------------------------------
// tb_dynamic_priority_scheduler
// directed and random load/tick traffic for the dynamic priority scheduler
// ----------------------------------------------------------------------------
// A short directed run covers the idle table, ties, saturation at the lowest
// priority, finished entries and reloads. Random episodes then load a few
// slots with mostly short run times and tick between 1 and 24 times, under
// four idling profiles on the request and response sides. The checker beside
// the block predicts and compares every response; this module only drives
// traffic and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dynamic_priority_scheduler;
   import dps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TB_ENTRIES     = DEF_NUM_ENTRIES;
   localparam int PHASE_REQUESTS = 250;
   localparam int LIMIT_CYCLES   = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   requests_sent;
   int   idle_pct;
   int   stall_pct;

   dps_req_if req_ch ();
   dps_rsp_if rsp_ch ();

   dynamic_priority_scheduler #(
      .NUM_ENTRIES(TB_ENTRIES)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   dps_sched_checker #(
      .NUM_ENTRIES(TB_ENTRIES)
   ) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: random back-pressure at the current stall rate
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // present one request after an optional idle gap, hold it until taken;
   // valid stays high on exit so back-to-back requests need no extra edge
   task automatic issue_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic signed [PRIO_W-1:0] prio,
                                input logic [TIME_W-1:0] remain);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.operation      <= op;
      req_ch.entry_index    <= slot;
      req_ch.start_priority <= prio;
      req_ch.start_time     <= remain;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   task automatic load_slot(input logic [SLOT_W-1:0] slot,
                            input logic signed [PRIO_W-1:0] prio,
                            input logic [TIME_W-1:0] remain);
      issue_request(OP_LOAD, slot, prio, remain);
   endtask

   // tick payload fields are don't-care, so fill them with noise
   task automatic tick();
      issue_request(OP_TICK, SLOT_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom));
   endtask

   // hold off the request side until every predicted response has arrived
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // extremes now and then, otherwise anything
   function automatic logic signed [PRIO_W-1:0] pick_priority();
      case ($urandom_range(7))
         0: return PRIO_MIN;
         1: return ~PRIO_MIN;
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   // short run times so the table drains and finish/all-done come often
   function automatic logic [TIME_W-1:0] pick_remain();
      case ($urandom_range(11))
         0: return TIME_W'($urandom_range(255));
         1: return {TIME_W{1'b1}};
         default: return TIME_W'($urandom_range(5));
      endcase
   endfunction

   // one episode: a burst of loads then a burst of ticks, sometimes scrambled
   task automatic run_episode();
      int n_loads;
      int n_ticks;
      n_loads = $urandom_range(1, 8);
      n_ticks = $urandom_range(1, 24);
      if ($urandom_range(7) == 0) begin
         // noise: loads and ticks interleaved at random
         repeat (n_loads + n_ticks) begin
            if ($urandom_range(1) == 0)
               load_slot(SLOT_W'($urandom), pick_priority(), pick_remain());
            else
               tick();
         end
      end else begin
         repeat (n_loads) load_slot(SLOT_W'($urandom), pick_priority(), pick_remain());
         repeat (n_ticks) tick();
      end
   endtask

   initial begin
      int phase_start;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.operation      <= OP_LOAD;
      req_ch.entry_index    <= '0;
      req_ch.start_priority <= '0;
      req_ch.start_time     <= '0;
      idle_pct      = 0;
      stall_pct     = 0;
      requests_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, nothing ready
      tick();
      // tie at the top priority goes to the lower slot
      load_slot(3'd0, ~PRIO_MIN, 8'd1);
      load_slot(3'd7, PRIO_MIN, 8'd255);
      load_slot(3'd3, ~PRIO_MIN, 8'd2);
      tick();
      tick();
      tick();
      // only the entry at the lowest priority is left; it must not wrap
      tick();
      tick();
      // reload to zero time retires the slot and removes its work
      load_slot(3'd7, 8'sd5, 8'd0);
      tick();
      // finished entry with a high priority must not compete
      load_slot(3'd4, 8'sd100, 8'd0);
      load_slot(3'd5, -8'sd1, 8'd3);
      load_slot(3'd2, -8'sd1, 8'd1);
      tick();
      tick();
      // reload of a live slot mid-run
      load_slot(3'd5, 8'sd64, 8'd2);
      tick();
      tick();
      tick();
      wait_drained();

      // random phases: none, request idle, response stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) run_episode();
         wait_drained();
      end

      // let any stray response show up before the verdict
      stall_pct = 0;
      repeat (4 * TB_ENTRIES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/dps_pkg.sv
rtl/core/dps_req_if.sv
rtl/core/dps_rsp_if.sv
rtl/core/dps_mem.sv
rtl/core/dps_sel.sv
rtl/core/dynamic_priority_scheduler.sv
verif/dps_sched_checker.sv
verif/tb_dynamic_priority_scheduler.sv
